>>> sv/iar_pkg.sv
package iar_pkg;

  // Text capacity including one terminator slot
  localparam int BufChars = 32;

  // Digit caps for non-negative and negative numbers
  localparam int CapMax = BufChars - 1;
  localparam int CntW   = $clog2(BufChars);
  localparam logic [CntW-1:0] CAP_POS = CntW'(BufChars - 1);
  localparam logic [CntW-1:0] CAP_NEG = CntW'(BufChars - 2);

  // Divider geometry: value width and quotient bits resolved per cycle
  localparam int ValW       = 64;
  localparam int DivStepBits = 8;
  localparam int DivCycles  = ValW / DivStepBits;
  localparam int DivCntW    = $clog2(DivCycles);

  localparam int DigitW = 4;
  localparam int RadixW = 5;

  localparam logic [RadixW-1:0] RADIX_MIN = RadixW'(2);
  localparam logic [RadixW-1:0] RADIX_MAX = RadixW'(16);

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOWA  = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // Divider status towards the sequencer
  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  // Digit stack operations
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  // Digit value to lower-case ASCII
  function automatic logic [7:0] digit_char(input logic [DigitW-1:0] d);
    logic [7:0] c;
    if (d < DigitW'(10)) begin
      c = CHAR_ZERO + 8'(d);
    end else begin
      c = CHAR_LOWA + 8'(d) - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> sv/iar_div.sv
module iar_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [iar_pkg::ValW-1:0]       dividend_i,
  input  logic [iar_pkg::RadixW-1:0]     radix_i,
  output logic [iar_pkg::ValW-1:0]       quot_o,
  output logic [iar_pkg::DigitW-1:0]     rem_o,
  output iar_pkg::div_stat_t             stat_o
);

  logic [iar_pkg::ValW-1:0]    q_q, q_d;
  logic [iar_pkg::DigitW-1:0]  r_q, r_d;
  logic [iar_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;

  // Restoring division, DivStepBits quotient bits per cycle
  always_comb begin
    logic [iar_pkg::DigitW:0] t;
    q_d = q_q;
    r_d = r_q;
    t   = '0;
    for (int k = 0; k < iar_pkg::DivStepBits; k++) begin
      t   = {r_d, q_d[iar_pkg::ValW-1]};
      q_d = {q_d[iar_pkg::ValW-2:0], 1'b0};
      if (t >= radix_i) begin
        t      = t - radix_i;
        q_d[0] = 1'b1;
      end
      r_d = t[iar_pkg::DigitW-1:0];
    end
  end

  // Control: busy from start until the step counter's last step, then a one-cycle done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == iar_pkg::DivCntW'(iar_pkg::DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign quot_o           = q_q;
  assign rem_o            = r_q;
  assign stat_o.done      = done_q;
  assign stat_o.quot_zero = (q_q == '0);

endmodule

>>> sv/iar_stack.sv
module iar_stack (
  input  logic                       clk_i,
  input  iar_pkg::stack_op_t         op_i,
  input  logic [iar_pkg::DigitW-1:0] digit_i,
  output logic [iar_pkg::DigitW-1:0] top_o
);

  // Shift-based LIFO: entry 0 is the top
  logic [iar_pkg::DigitW-1:0] ent_q [iar_pkg::CapMax];

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      ent_q[0] <= digit_i;
      for (int i = 1; i < iar_pkg::CapMax; i++) begin
        ent_q[i] <= ent_q[i-1];
      end
    end else if (op_i.pop) begin
      for (int i = 0; i < iar_pkg::CapMax - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

  assign top_o = ent_q[0];

endmodule

>>> sv/integer_to_ascii_radix_unit.sv
// Channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o | value_i, is_signed_i, base_i
// out     | output    | out_valid_o / out_ready_i | character_o, last_o
//
// Each digit takes a launch step in S_START, the shared radix divider (8 quotient
// bits per cycle over 64 bits) while in S_WAIT, and a collect step on its done.
// An item takes an accept step, the digit steps, one more S_START visit when the
// digit cap ends the conversion, and one emit step per character, held by output
// stalls; in_ready_o is high only while the sequencer is idle, so a new number waits.
// Reset is asynchronous and clears the sequencer and the output valid.
// A stalled output holds the sequencer in its emit phase; no character is lost.
module integer_to_ascii_radix_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_i,
  input  logic        is_signed_i,
  input  logic [4:0]  base_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e                          state_q;
  logic [iar_pkg::ValW-1:0]        mag_q;
  logic [iar_pkg::RadixW-1:0]      radix_q;
  logic [iar_pkg::CntW-1:0]        cap_q;
  logic [iar_pkg::CntW-1:0]        n_q;
  logic                            neg_q;
  logic                            out_valid_q;
  logic [7:0]                      char_q;
  logic                            last_q;

  logic [iar_pkg::ValW-1:0]        quot;
  logic [iar_pkg::DigitW-1:0]      rem;
  logic [iar_pkg::DigitW-1:0]      top;
  iar_pkg::div_stat_t              div_stat;
  iar_pkg::stack_op_t              stack_op;
  logic                            div_start;
  logic                            out_free;
  logic                            emit;
  logic                            in_neg;
  logic [iar_pkg::RadixW-1:0]      in_radix;

  // Input decode: sign, clamped radix
  always_comb begin
    in_neg = is_signed_i & value_i[iar_pkg::ValW-1];
    if (base_i < iar_pkg::RADIX_MIN) begin
      in_radix = iar_pkg::RADIX_MIN;
    end else if (base_i > iar_pkg::RADIX_MAX) begin
      in_radix = iar_pkg::RADIX_MAX;
    end else begin
      in_radix = base_i;
    end
  end

  // Unit controls
  assign out_free      = !out_valid_q || out_ready_i;
  assign emit          = ((state_q == S_SIGN) || (state_q == S_EMIT)) && out_free;
  assign div_start     = (state_q == S_START) && (n_q != cap_q);
  assign stack_op.push = (state_q == S_WAIT) && div_stat.done;
  assign stack_op.pop  = (state_q == S_EMIT) && out_free;

  iar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .radix_i    (radix_q),
    .quot_o     (quot),
    .rem_o      (rem),
    .stat_o     (div_stat)
  );

  iar_stack u_stack (
    .clk_i   (clk_i),
    .op_i    (stack_op),
    .digit_i (rem),
    .top_o   (top)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      radix_q     <= '0;
      cap_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // Output valid: set on a new character, cleared on transfer
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            neg_q   <= in_neg;
            mag_q   <= in_neg ? (~value_i + 64'd1) : value_i;
            radix_q <= in_radix;
            cap_q   <= in_neg ? iar_pkg::CAP_NEG : iar_pkg::CAP_POS;
            n_q     <= '0;
            state_q <= S_START;
          end
        end
        S_START: begin
          if (n_q == cap_q) begin
            state_q <= neg_q ? S_SIGN : S_EMIT;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_stat.done) begin
            n_q   <= n_q + 1'b1;
            mag_q <= quot;
            if (div_stat.quot_zero) begin
              state_q <= neg_q ? S_SIGN : S_EMIT;
            end else begin
              state_q <= S_START;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            char_q      <= iar_pkg::CHAR_MINUS;
            last_q      <= (n_q == '0);
            state_q     <= (n_q == '0) ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            char_q      <= iar_pkg::digit_char(top);
            last_q      <= (n_q == iar_pkg::CntW'(1));
            n_q         <= n_q - 1'b1;
            if (n_q == iar_pkg::CntW'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

>>> sv/iar_checker.sv
module iar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  character_o,
  input logic        last_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output dropped while stalled");

  // After a transfer in, the unit is busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Returning to idle coincides with the final character being offered
  a_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && last_o)
    else $error("idle without final character");

  // Only digits, lower-case a-f or minus are emitted
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o >= 8'h30 && character_o <= 8'h39) ||
                    (character_o >= 8'h61 && character_o <= 8'h66) ||
                    (character_o == 8'h2d))
    else $error("bad character code");

endmodule

bind integer_to_ascii_radix_unit iar_checker u_iar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .last_o      (last_o)
);

>>> tb/tb_integer_to_ascii_radix_unit.sv
module tb_integer_to_ascii_radix_unit;

  // One emitted character as the block should present it
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Text predictor and in-order checker of emitted characters
  class ascii_scoreboard;
    text_char_t digit_text_q[$];
    int         errors;
    int         numbers;
    int         chars;
    string      glyphs;

    function new();
      errors  = 0;
      numbers = 0;
      chars   = 0;
      glyphs  = "0123456789abcdef";
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Work out the text of one accepted number and queue its characters
    function void render_number(input logic [63:0] value, input logic is_signed,
                                input logic [4:0] base);
      logic [63:0] mag;
      logic [63:0] radix;
      logic [3:0]  dig;
      logic [7:0]  digs [64];
      logic        neg;
      int          cap;
      int          n;
      radix = 64'(base);
      if (base < iar_pkg::RADIX_MIN) radix = 64'(iar_pkg::RADIX_MIN);
      if (base > iar_pkg::RADIX_MAX) radix = 64'(iar_pkg::RADIX_MAX);
      neg = is_signed & value[63];
      mag = neg ? ~value + 64'd1 : value;
      cap = neg ? iar_pkg::BufChars - 2 : iar_pkg::BufChars - 1;
      n   = 0;
      // low-order digits first; the cap drops the high-order ones
      if (mag == 64'd0) begin
        if (cap >= 1) begin
          digs[0] = iar_pkg::CHAR_ZERO;
          n = 1;
        end
      end else begin
        while (mag != 64'd0 && n < cap) begin
          dig     = 4'(mag % radix);
          digs[n] = glyphs[dig];
          n++;
          mag = mag / radix;
        end
      end
      if (neg) digit_text_q.push_back('{iar_pkg::CHAR_MINUS, n == 0});
      for (int i = n - 1; i >= 0; i--) digit_text_q.push_back('{digs[i], i == 0});
      numbers++;
    endfunction

    task check_char(input logic [7:0] code, input logic last);
      text_char_t want;
      chars++;
      if (digit_text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b", code, last));
      end else begin
        want = digit_text_q.pop_front();
        if (code !== want.code)
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h", code, want.code));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b (character 0x%02h)",
                                    last, want.last, want.code));
      end
    endtask

    function int pending();
      return digit_text_q.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [63:0] value_i     = '0;
  logic        is_signed_i = 1'b0;
  logic [4:0]  base_i      = 5'd10;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  character_o;
  logic        last_o;

  int src_idle_pct  = 6;
  int sink_idle_pct = 67;
  int stall_left    = 0;

  ascii_scoreboard sb = new();

  integer_to_ascii_radix_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .is_signed_i (is_signed_i),
    .base_i      (base_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receive side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_char(character_o, last_o);
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one number and hold it until the transfer
  task automatic send_number(input logic [63:0] v, input logic s, input logic [4:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    value_i     <= v;
    is_signed_i <= s;
    base_i      <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.render_number(v, s, b);
  endtask

  task automatic send_random_number();
    logic [63:0] v;
    logic        s;
    logic [4:0]  b;
    case ($urandom_range(5))
      0, 1:    v = {$urandom, $urandom};
      2:       v = 64'($urandom_range(1000));
      3:       v = -64'($urandom_range(1000));
      4:       v = 64'd1 << $urandom_range(63);
      default: v = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    s = 1'($urandom_range(1));
    // mostly legal radices, now and then anything the field holds
    b = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 2));
    send_number(v, s, b);
  endtask

  // Stop offering and wait for all queued text
  task automatic drain_text();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, extremes, digit cap, most negative, clamped radices
    send_number(64'd0, 1'b0, 5'd10);
    send_number(64'd0, 1'b1, 5'd2);
    send_number('1, 1'b0, 5'd2);
    send_number('1, 1'b0, 5'd16);
    send_number('1, 1'b0, 5'd10);
    send_number('1, 1'b1, 5'd10);
    send_number(64'h8000_0000_0000_0000, 1'b1, 5'd2);
    send_number(64'h8000_0000_0000_0000, 1'b1, 5'd16);
    send_number(64'h8000_0000_0000_0000, 1'b0, 5'd8);
    send_number(64'h7fff_ffff_ffff_ffff, 1'b1, 5'd2);
    send_number(64'd5, 1'b0, 5'd0);
    send_number(64'd5, 1'b1, 5'd1);
    send_number(64'habc, 1'b0, 5'd17);
    send_number(64'habc, 1'b0, 5'd31);
    for (int r = 2; r <= 16; r++)
      send_number(64'hfedc_ba98_7654_3210, 1'(r), 5'(r));
    drain_text();

    // slow receiver, with one long hold-off while input keeps coming
    for (int i = 0; i < 100; i++) begin
      if (i == 40) stall_left = 3000;
      send_random_number();
    end
    drain_text();

    src_idle_pct  = 67;
    sink_idle_pct = 6;
    for (int i = 0; i < 100; i++) send_random_number();
    drain_text();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (int i = 0; i < 100; i++) send_random_number();
    drain_text();
    repeat (50) @(posedge clk_i);

    $display("Converted %0d numbers into %0d characters, radix field 0-31, signed and unsigned",
             sb.numbers, sb.chars);
    $display("Included digit cap, most negative value, long output stall; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("integer_to_ascii_radix_unit test passed");
    end else begin
      $display("integer_to_ascii_radix_unit test failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("integer_to_ascii_radix_unit test failed");
    $finish;
  end

endmodule
